// ----- src/sbusr_pkg.sv -----
// sbusr_pkg: constants, status codes and the frame entry type for the
// serial frame receiver. Used by every module of the block.
`default_nettype none
package sbusr_pkg;

  localparam int FRAME_LENGTH = 25;
  localparam int CH_WIDTH     = 11;
  localparam int NUM_PROP     = 16;
  localparam int DATA_BITS    = (FRAME_LENGTH - 3) * 8;
  localparam int SHIFT_BITS   = (FRAME_LENGTH - 2) * 8;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LOST_FLAG_BIT = 2;

  localparam logic [7:0]          START_BYTE       = 8'h0F;
  localparam logic [7:0]          END_BYTE         = 8'h00;
  localparam logic [7:0]          LOST_LIMIT_RESET = 8'd10;
  localparam logic [CH_WIDTH-1:0] DIGITAL_ON       = 11'h7FF;
  localparam logic [4:0]          LAST_POS         = 5'(FRAME_LENGTH - 1);
  localparam logic [4:0]          DIG0_INDEX       = 5'(NUM_PROP);
  localparam logic [4:0]          DIG1_INDEX       = 5'(NUM_PROP + 1);

  typedef enum logic [1:0] {
    STATUS_GOOD    = 2'd0,
    STATUS_LOST    = 2'd1,
    STATUS_BAD_END = 2'd2
  } status_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] data;
    logic [1:0]           digital;
    status_t              status;
    logic [7:0]           lost_count;
    logic [15:0]          error_count;
    logic                 reset_request;
    logic                 link_seen;
  } frame_entry_t;

endpackage
`default_nettype wire

// ----- src/sbusr_front.sv -----
// sbusr_front: byte framing, frame classification and the status counters.
// Depends on sbusr_pkg; pushes one entry per completed frame.
`default_nettype none
module sbusr_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [7:0]            cfg_wr_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            rx_byte,
  input  wire logic                  q_full,
  output logic                       push,
  output sbusr_pkg::frame_entry_t    entry
);
  import sbusr_pkg::*;

  logic [4:0]            byte_position;
  logic [7:0]            lost_cnt;
  logic [15:0]           err_cnt;
  logic                  seen_good;
  logic [7:0]            lost_limit;
  logic [SHIFT_BITS-1:0] shift_reg;

  logic       accept;
  logic [7:0] flags;
  logic [7:0] lost_inc;
  logic [15:0] err_inc;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && (byte_position == LAST_POS);
  assign flags    = shift_reg[SHIFT_BITS-1 -: 8];
  assign lost_inc = (lost_cnt == 8'hFF) ? lost_cnt : lost_cnt + 8'd1;
  assign err_inc  = (err_cnt == 16'hFFFF) ? err_cnt : err_cnt + 16'd1;

  always_comb begin
    entry.data          = shift_reg[DATA_BITS-1:0];
    entry.digital       = flags[1:0];
    entry.status        = STATUS_GOOD;
    entry.lost_count    = lost_cnt;
    entry.error_count   = err_cnt;
    entry.reset_request = 1'b0;
    entry.link_seen     = seen_good;
    if (rx_byte != END_BYTE) begin
      entry.status      = STATUS_BAD_END;
      entry.error_count = err_inc;
    end else if (flags[LOST_FLAG_BIT]) begin
      entry.status        = STATUS_LOST;
      entry.lost_count    = lost_inc;
      entry.reset_request = (lost_inc > lost_limit);
    end else begin
      entry.link_seen = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      lost_cnt      <= '0;
      err_cnt       <= '0;
      seen_good     <= 1'b0;
      lost_limit    <= LOST_LIMIT_RESET;
    end else begin
      if (cfg_wr_en) begin
        lost_limit <= cfg_wr_data;
      end
      if (accept) begin
        if (byte_position == '0) begin
          if (rx_byte == START_BYTE) begin
            byte_position <= 5'd1;
          end
        end else if (byte_position != LAST_POS) begin
          byte_position <= byte_position + 5'd1;
        end else begin
          byte_position <= '0;
          if (entry.reset_request) begin
            lost_cnt  <= '0;
            err_cnt   <= '0;
            seen_good <= 1'b0;
          end else begin
            lost_cnt  <= entry.lost_count;
            err_cnt   <= entry.error_count;
            seen_good <= entry.link_seen;
          end
        end
      end
    end
  end

  // shift data bytes in from the top; byte 1 ends up in the low bits
  always_ff @(posedge clk) begin
    if (accept && byte_position != '0 && byte_position != LAST_POS) begin
      shift_reg <= {rx_byte, shift_reg[SHIFT_BITS-1:8]};
    end
  end

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full) else $error("frame pushed into full queue");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= LAST_POS) else $error("byte position out of range");
  a_req_clears: assert property (@(posedge clk) disable iff (rst)
    push && entry.reset_request |=> lost_cnt == '0 && err_cnt == '0 && !seen_good)
    else $error("counters not cleared after reset request");

endmodule
`default_nettype wire

// ----- src/sbusr_queue.sv -----
// sbusr_queue: short frame entry queue between front and back.
// Depends on sbusr_pkg for the entry type and depth.
`default_nettype none
module sbusr_queue (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  input  wire sbusr_pkg::frame_entry_t  wr_entry,
  output logic                          full,
  input  wire logic                     pop,
  output logic                          empty,
  output sbusr_pkg::frame_entry_t       rd_entry
);
  import sbusr_pkg::*;

  frame_entry_t      entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign rd_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule
`default_nettype wire

// ----- src/sbusr_back.sv -----
// sbusr_back: unpacks one queued frame into channel result beats.
// Depends on sbusr_pkg; drives the output register of the block.
`default_nettype none
module sbusr_back (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     empty,
  input  wire sbusr_pkg::frame_entry_t  head,
  output logic                          pop,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [4:0]                    channel_index,
  output logic [10:0]                   channel_value,
  output logic [1:0]                    status,
  output logic [7:0]                    lost_count,
  output logic [15:0]                   error_count,
  output logic                          reset_request,
  output logic                          link_seen,
  output logic                          last
);
  import sbusr_pkg::*;

  logic         active;
  logic [4:0]   idx;
  frame_entry_t cur;

  logic                emit;
  logic                beat_last;
  logic [4:0]          beat_index;
  logic [CH_WIDTH-1:0] beat_value;

  assign emit = active && (!out_valid || !out_stall);
  assign pop  = !active && !empty;

  always_comb begin
    beat_index = idx;
    beat_last  = (idx == DIG1_INDEX);
    if (cur.status == STATUS_BAD_END) begin
      beat_index = '0;
      beat_value = '0;
      beat_last  = 1'b1;
    end else if (idx < DIG0_INDEX) begin
      beat_value = cur.data[CH_WIDTH-1:0];
    end else if (idx == DIG0_INDEX) begin
      beat_value = cur.digital[0] ? DIGITAL_ON : '0;
    end else begin
      beat_value = cur.digital[1] ? DIGITAL_ON : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        active <= 1'b1;
        idx    <= '0;
        cur    <= head;
      end else if (emit) begin
        idx      <= idx + 5'd1;
        cur.data <= cur.data >> CH_WIDTH;
        if (beat_last) begin
          active <= 1'b0;
        end
      end
      if (emit) begin
        out_valid     <= 1'b1;
        channel_index <= beat_index;
        channel_value <= beat_value;
        status        <= cur.status;
        lost_count    <= cur.lost_count;
        error_count   <= cur.error_count;
        reset_request <= cur.reset_request;
        link_seen     <= cur.link_seen;
        last          <= beat_last;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> channel_index == DIG1_INDEX || status == STATUS_BAD_END)
    else $error("last beat on wrong channel");
  a_bad_end_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_BAD_END |-> last && channel_value == '0)
    else $error("bad end beat malformed");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> !active) else $error("pop while frame active");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    active |-> idx <= DIG1_INDEX) else $error("channel index overrun");

endmodule
`default_nettype wire

// ----- src/sbus_frame_receiver.sv -----
// sbus_frame_receiver: takes one serial byte per cycle while in_stall is low;
// results pass the queue, back frame register and output register, one per
// cycle while out_stall is low (18 per good frame, 1 per bad end byte), set by
// the back part's channel counter; the back part holds one frame at a time.
// Synchronous reset clears framing, counters and queue; lost_limit becomes 10.
`default_nettype none
module sbus_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       channel_index,
  output logic [10:0]      channel_value,
  output logic [1:0]       status,
  output logic [7:0]       lost_count,
  output logic [15:0]      error_count,
  output logic             reset_request,
  output logic             link_seen,
  output logic             last
);
  import sbusr_pkg::*;

  logic         push;
  logic         q_full;
  logic         q_empty;
  logic         pop;
  frame_entry_t wr_entry;
  frame_entry_t rd_entry;

  sbusr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .q_full      (q_full),
    .push        (push),
    .entry       (wr_entry)
  );

  sbusr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .rd_entry (rd_entry)
  );

  sbusr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (q_empty),
    .head          (rd_entry),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .status        (status),
    .lost_count    (lost_count),
    .error_count   (error_count),
    .reset_request (reset_request),
    .link_seen     (link_seen),
    .last          (last)
  );

endmodule
`default_nettype wire
